// ----- rtl/column_aggregate_accumulator_unit_assert.svh -----
// Assertion macros for the column aggregate accumulator
`ifndef COLUMN_AGGREGATE_ACCUMULATOR_UNIT_ASSERT_SVH
`define COLUMN_AGGREGATE_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CAA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAA_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/caa_pkg.sv -----
`default_nettype none
package caa_pkg;

  localparam int unsigned MaxCols = 4;
  localparam int unsigned ColW    = 2;
  localparam int unsigned CntW    = 32;
  localparam int unsigned DataW   = 64;
  localparam int unsigned BucketW = 32;
  localparam int unsigned ModeW   = 4;
  localparam int unsigned InDataW = 520;
  localparam int unsigned OutDataW = 520;
  localparam int unsigned AddrW   = 5;

  // mode codes
  localparam logic [ModeW-1:0] ModeNone      = 4'd0;
  localparam logic [ModeW-1:0] ModeCount     = 4'd1;
  localparam logic [ModeW-1:0] ModeSum       = 4'd2;
  localparam logic [ModeW-1:0] ModeAvg       = 4'd3;
  localparam logic [ModeW-1:0] ModeMin       = 4'd4;
  localparam logic [ModeW-1:0] ModeMax       = 4'd5;
  localparam logic [ModeW-1:0] ModeVwap      = 4'd6;
  localparam logic [ModeW-1:0] ModeFirstLast = 4'd7;
  localparam logic [ModeW-1:0] ModeXbar      = 4'd8;

  // commands carried in tuser
  localparam logic CmdAccum   = 1'b0;
  localparam logic CmdReadout = 1'b1;

  // register bank select (upper index bit)
  localparam logic RegModeSel   = 1'b0;
  localparam logic RegBucketSel = 1'b1;

  localparam logic [DataW-1:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] Int64Min = 64'h8000_0000_0000_0000;
  localparam logic [CntW-1:0]  CntMax   = '1;

  typedef struct packed {
    logic [DataW-1:0] val;
    logic [DataW-1:0] vol;
    logic             vp;
    logic             wp;
  } lane_in_t;

  typedef struct packed {
    logic [CntW-1:0]  tally;
    logic [DataW-1:0] total;
    logic [DataW-1:0] minimum;
    logic [DataW-1:0] maximum;
    logic [DataW-1:0] pv_sum;
    logic [DataW-1:0] vol_sum;
    logic [DataW-1:0] first;
    logic [DataW-1:0] last;
    logic             seen;
  } lane_state_t;

  localparam lane_state_t LaneReset = '{
    tally: '0, total: '0, minimum: Int64Max, maximum: Int64Min,
    pv_sum: '0, vol_sum: '0, first: '0, last: '0, seen: 1'b0
  };

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] x);
    sat_inc = (x == CntMax) ? x : x + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/caa_lane.sv -----
`default_nettype none
module caa_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 clear_i,
  input  caa_pkg::lane_in_t    in_i,
  input  logic [3:0]           mode_i,
  input  logic [31:0]          bucket_i,
  output logic                 busy_o,
  output caa_pkg::lane_state_t state_o
);
  import caa_pkg::*;

  typedef enum logic [2:0] {
    LANE_IDLE = 3'b001,
    LANE_MUL  = 3'b010,
    LANE_DIV  = 3'b100
  } lane_fsm_e;

  lane_fsm_e         fsm_q, fsm_d;
  lane_state_t       st_q, st_d;
  logic [DataW-1:0]  pp_ll_q;
  logic [31:0]       pp_lh_q, pp_hl_q;
  logic [DataW-1:0]  vol_q;
  logic [DataW-1:0]  mag_q, mag_d, orig_q, orig_d;
  logic [BucketW-1:0] rem_q, rem_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [DataW-1:0]  prod_ll;
  logic [31:0]       prod_lh, prod_hl;
  logic [BucketW:0]  rem_shift;
  logic [BucketW-1:0] rem_next;
  logic [DataW-1:0]  in_mag;

  // 32x32 partial products of the wrapping 64-bit product
  assign prod_ll = DataW'(in_i.val[31:0]) * DataW'(in_i.vol[31:0]);
  assign prod_lh = in_i.val[31:0] * in_i.vol[63:32];
  assign prod_hl = in_i.val[63:32] * in_i.vol[31:0];

  // magnitude of the incoming value for the xbar divider
  assign in_mag = in_i.val[DataW-1] ? (~in_i.val + 1'b1) : in_i.val;

  // one restoring division step
  always_comb begin
    rem_shift = {rem_q, mag_q[DataW-1]};
    if (rem_shift >= {1'b0, bucket_i}) begin
      rem_next = BucketW'(rem_shift - {1'b0, bucket_i});
    end else begin
      rem_next = rem_shift[BucketW-1:0];
    end
  end

  // next state of the accumulators
  always_comb begin
    st_d   = st_q;
    fsm_d  = fsm_q;
    mag_d  = mag_q;
    orig_d = orig_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    if (clear_i) begin
      st_d  = LaneReset;
      fsm_d = LANE_IDLE;
    end else begin
      unique case (fsm_q)
        LANE_IDLE: begin
          if (start_i) begin
            case (mode_i)
              ModeCount: st_d.tally = sat_inc(st_q.tally);
              ModeSum: begin
                if (in_i.vp) st_d.total = st_q.total + in_i.val;
              end
              ModeAvg: begin
                if (in_i.vp) begin
                  st_d.total = st_q.total + in_i.val;
                  st_d.tally = sat_inc(st_q.tally);
                end
              end
              ModeMin: begin
                if (in_i.vp && ($signed(in_i.val) < $signed(st_q.minimum))) begin
                  st_d.minimum = in_i.val;
                end
              end
              ModeMax: begin
                if (in_i.vp && ($signed(in_i.val) > $signed(st_q.maximum))) begin
                  st_d.maximum = in_i.val;
                end
              end
              ModeVwap: begin
                if (in_i.vp && in_i.wp) fsm_d = LANE_MUL;
              end
              ModeFirstLast: begin
                if (in_i.vp) begin
                  if (!st_q.seen) begin
                    st_d.first = in_i.val;
                    st_d.seen  = 1'b1;
                  end
                  st_d.last = in_i.val;
                end
              end
              ModeXbar: begin
                if (in_i.vp && !st_q.seen) begin
                  if (bucket_i == '0) begin
                    st_d.first = in_i.val;
                    st_d.seen  = 1'b1;
                  end else begin
                    fsm_d  = LANE_DIV;
                    mag_d  = in_mag;
                    orig_d = in_mag;
                    rem_d  = '0;
                    cnt_d  = '0;
                    neg_d  = in_i.val[DataW-1];
                  end
                end
              end
              default: ;
            endcase
          end
        end
        LANE_MUL: begin
          st_d.pv_sum  = st_q.pv_sum + pp_ll_q + {pp_lh_q + pp_hl_q, 32'b0};
          st_d.vol_sum = st_q.vol_sum + vol_q;
          fsm_d        = LANE_IDLE;
        end
        LANE_DIV: begin
          mag_d = {mag_q[DataW-2:0], 1'b0};
          rem_d = rem_next;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == '1) begin
            // bucketed value is |v| - r, sign restored
            st_d.first = neg_q ? (DataW'(rem_next) - orig_q) : (orig_q - DataW'(rem_next));
            st_d.seen  = 1'b1;
            fsm_d      = LANE_IDLE;
          end
        end
        default: fsm_d = LANE_IDLE;
      endcase
    end
  end

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= LANE_IDLE;
      st_q  <= LaneReset;
      cnt_q <= '0;
    end else begin
      fsm_q <= fsm_d;
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pp_ll_q <= prod_ll;
      pp_lh_q <= prod_lh;
      pp_hl_q <= prod_hl;
      vol_q   <= in_i.vol;
    end
    mag_q  <= mag_d;
    orig_q <= orig_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
  end

  assign busy_o  = (fsm_q != LANE_IDLE);
  assign state_o = st_q;

endmodule
`default_nettype wire

// ----- rtl/caa_merge.sv -----
`default_nettype none
module caa_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [1:0]           sel_i,
  input  logic                 last_i,
  input  logic [31:0]          rows_i,
  input  caa_pkg::lane_state_t lanes_i [caa_pkg::MaxCols],
  output logic                 free_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: tally, total, minimum, maximum, price_volume, volume_total,
  //        first_value, last_value, seen, rows, zero pad
  output logic [caa_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: column
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);
  import caa_pkg::*;

  logic                valid_q;
  lane_state_t         sel_st;
  logic [OutDataW-1:0] data_q;
  logic [ColW-1:0]     col_q;
  logic                last_q;

  assign sel_st = lanes_i[sel_i];
  assign free_o = !valid_q || m_axis_tready;

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // selected lane packed into the output register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {7'b0, rows_i, sel_st.seen, sel_st.last, sel_st.first,
                 sel_st.vol_sum, sel_st.pv_sum, sel_st.maximum,
                 sel_st.minimum, sel_st.total, sel_st.tally};
      col_q  <= sel_i;
      last_q <= last_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = col_q;
  assign m_axis_tlast  = last_q;

endmodule
`default_nettype wire

// ----- rtl/column_aggregate_accumulator_unit.sv -----
// Accumulate: a transaction waits in TOP_ACC until no lane is busy; a column in
//   vwap mode adds a LANE_MUL step (registered partial products), and an xbar
//   column capturing its first value runs the lane divider (one quotient bit per cycle).
// Throughput: one transaction at a time; a readout emits COLUMNS results,
//   one per cycle while the sink is ready, and then clears all columns.
// Reset: rst_ni is asynchronous, active low; clears config and column state.
`default_nettype none
`include "column_aggregate_accumulator_unit_assert.svh"
module column_aggregate_accumulator_unit #(
  parameter int unsigned Columns = caa_pkg::MaxCols
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: val0..val3, vol0..vol3, val_present, vol_present
  input  logic [caa_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: cmd
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: tally, total, minimum, maximum, price_volume, volume_total,
  //        first_value, last_value, seen, rows, zero pad
  output logic [caa_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: column
  output logic [1:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [caa_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import caa_pkg::*;

  typedef enum logic [2:0] {
    TOP_IDLE = 3'b001,
    TOP_ACC  = 3'b010,
    TOP_OUT  = 3'b100
  } top_fsm_e;

  localparam logic [ColW-1:0] LastCol = ColW'(Columns - 1);

  logic [ModeW-1:0]   mode_q   [MaxCols];
  logic [BucketW-1:0] bucket_q [MaxCols];
  top_fsm_e           fsm_q, fsm_d;
  logic [CntW-1:0]    rows_q, rows_d;
  logic [ColW-1:0]    col_q, col_d;
  logic               in_acc, start, clear, load, out_free, cfg_wr;
  logic [2:0]         reg_idx;
  logic [MaxCols-1:0] busy;
  lane_state_t        lane_st [MaxCols];

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxCols; i++) begin
        mode_q[i]   <= ModeNone;
        bucket_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      if (reg_idx[2] == RegBucketSel) begin
        bucket_q[reg_idx[1:0]] <= pwdata;
      end else begin
        mode_q[reg_idx[1:0]] <= pwdata[ModeW-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx[2] == RegBucketSel) begin
      prdata = bucket_q[reg_idx[1:0]];
    end else begin
      prdata = {28'b0, mode_q[reg_idx[1:0]]};
    end
  end

  // input handshake
  assign s_axis_tready = (fsm_q == TOP_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign start         = in_acc && (s_axis_tuser == CmdAccum);
  assign load          = (fsm_q == TOP_OUT) && out_free;
  assign clear         = load && (col_q == LastCol);

  // lanes, one per column
  for (genvar c = 0; c < MaxCols; c++) begin : g_lane
    if (c < Columns) begin : g_on
      lane_in_t lin;
      assign lin.val = s_axis_tdata[DataW*c +: DataW];
      assign lin.vol = s_axis_tdata[DataW*(MaxCols+c) +: DataW];
      assign lin.vp  = s_axis_tdata[2*MaxCols*DataW + c];
      assign lin.wp  = s_axis_tdata[2*MaxCols*DataW + MaxCols + c];
      caa_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .start_i  (start),
        .clear_i  (clear),
        .in_i     (lin),
        .mode_i   (mode_q[c]),
        .bucket_i (bucket_q[c]),
        .busy_o   (busy[c]),
        .state_o  (lane_st[c])
      );
    end else begin : g_off
      assign busy[c]    = 1'b0;
      assign lane_st[c] = LaneReset;
    end
  end

  // sequencer
  always_comb begin
    fsm_d  = fsm_q;
    rows_d = rows_q;
    col_d  = col_q;
    unique case (fsm_q)
      TOP_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == CmdReadout) begin
            fsm_d = TOP_OUT;
          end else begin
            fsm_d  = TOP_ACC;
            rows_d = sat_inc(rows_q);
          end
        end
      end
      TOP_ACC: begin
        if (!(|busy)) fsm_d = TOP_IDLE;
      end
      TOP_OUT: begin
        if (load) begin
          if (col_q == LastCol) begin
            col_d  = '0;
            rows_d = '0;
            fsm_d  = TOP_IDLE;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: fsm_d = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q  <= TOP_IDLE;
      rows_q <= '0;
      col_q  <= '0;
    end else begin
      fsm_q  <= fsm_d;
      rows_q <= rows_d;
      col_q  <= col_d;
    end
  end

  // column select and output register
  caa_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .sel_i         (col_q),
    .last_i        (col_q == LastCol),
    .rows_i        (rows_q),
    .lanes_i       (lane_st),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `CAA_ASSERT(a_ready_lanes_idle, clk_i, rst_ni, s_axis_tready |-> !(|busy), "input ready while a lane is busy")
  `CAA_ASSERT(a_last_col, clk_i, rst_ni, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == LastCol), "tlast on wrong column")
  `CAA_ASSERT(a_acc_wait, clk_i, rst_ni, start |=> (fsm_q == TOP_ACC), "accumulate did not wait for lanes")

endmodule
`default_nettype wire

// ----- bench/aggregate_checker.sv -----
`timescale 1ns / 100ps
module aggregate_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [519:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [519:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending_o
);
  import caa_pkg::*;

  typedef struct packed {
    logic [1:0]  column;
    logic [31:0] tally;
    logic [63:0] total;
    logic [63:0] minimum;
    logic [63:0] maximum;
    logic [63:0] pv;
    logic [63:0] vsum;
    logic [63:0] first;
    logic [63:0] last;
    logic        seen;
    logic [31:0] rows;
    logic        last_of_run;
  } col_result_t;

  // configuration shadow, tracked from the register bus
  logic [3:0]  mode_q   [4];
  logic [31:0] bucket_q [4];
  // column state shadow
  logic [31:0] tally_q [4];
  logic [63:0] total_q [4];
  logic [63:0] min_q   [4];
  logic [63:0] max_q   [4];
  logic [63:0] pv_q    [4];
  logic [63:0] vsum_q  [4];
  logic [63:0] first_q [4];
  logic [63:0] last_q  [4];
  logic        seen_q  [4];
  logic [31:0] rows_q;

  col_result_t readout_q[$];

  assign pending_o = readout_q.size();

  function automatic logic [31:0] count_up(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  task automatic clear_columns();
    for (int c = 0; c < 4; c++) begin
      tally_q[c] = '0; total_q[c] = '0; min_q[c] = Int64Max; max_q[c] = Int64Min;
      pv_q[c] = '0; vsum_q[c] = '0; first_q[c] = '0; last_q[c] = '0;
      seen_q[c] = 1'b0;
    end
    rows_q = '0;
  endtask

  task automatic fold_row(input logic [519:0] d);
    logic [63:0]        v, w;
    logic               vp, wp;
    logic signed [63:0] sb;
    for (int c = 0; c < 4; c++) begin
      v  = d[64*c +: 64];
      w  = d[256 + 64*c +: 64];
      vp = d[512 + c];
      wp = d[516 + c];
      case (mode_q[c])
        ModeCount: tally_q[c] = count_up(tally_q[c]);
        ModeSum:   if (vp) total_q[c] = total_q[c] + v;
        ModeAvg: begin
          if (vp) begin
            total_q[c] = total_q[c] + v;
            tally_q[c] = count_up(tally_q[c]);
          end
        end
        ModeMin: if (vp && $signed(v) < $signed(min_q[c])) min_q[c] = v;
        ModeMax: if (vp && $signed(v) > $signed(max_q[c])) max_q[c] = v;
        ModeVwap: begin
          if (vp && wp) begin
            pv_q[c]   = pv_q[c] + v * w;
            vsum_q[c] = vsum_q[c] + w;
          end
        end
        ModeFirstLast: begin
          if (vp) begin
            if (!seen_q[c]) begin
              first_q[c] = v;
              seen_q[c]  = 1'b1;
            end
            last_q[c] = v;
          end
        end
        ModeXbar: begin
          if (vp && !seen_q[c]) begin
            sb = $signed({32'd0, bucket_q[c]});
            first_q[c] = (bucket_q[c] != 0) ? ($signed(v) / sb) * sb : $signed(v);
            seen_q[c]  = 1'b1;
          end
        end
        default: ;
      endcase
    end
    rows_q = count_up(rows_q);
  endtask

  task automatic emit_readout();
    col_result_t r;
    for (int c = 0; c < 4; c++) begin
      r = '{column: c[1:0], tally: tally_q[c], total: total_q[c], minimum: min_q[c],
            maximum: max_q[c], pv: pv_q[c], vsum: vsum_q[c], first: first_q[c],
            last: last_q[c], seen: seen_q[c], rows: rows_q, last_of_run: (c == 3)};
      readout_q.push_back(r);
    end
    clear_columns();
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    col_result_t e;
    if (readout_q.size() == 0) begin
      $display("%0t: unexpected result transaction, expected none, actual %h",
               $time, m_axis_tdata);
      fail_count++;
      return;
    end
    e = readout_q.pop_front();
    check_field("column", e.column, m_axis_tuser);
    check_field("tally", e.tally, m_axis_tdata[31:0]);
    check_field("total", e.total, m_axis_tdata[95:32]);
    check_field("minimum", e.minimum, m_axis_tdata[159:96]);
    check_field("maximum", e.maximum, m_axis_tdata[223:160]);
    check_field("price_volume", e.pv, m_axis_tdata[287:224]);
    check_field("volume_total", e.vsum, m_axis_tdata[351:288]);
    check_field("first_value", e.first, m_axis_tdata[415:352]);
    check_field("last_value", e.last, m_axis_tdata[479:416]);
    check_field("seen", e.seen, m_axis_tdata[480]);
    check_field("rows", e.rows, m_axis_tdata[512:481]);
    check_field("last_of_run", e.last_of_run, m_axis_tlast);
  endtask

  // watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count = 0;
      for (int c = 0; c < 4; c++) begin
        mode_q[c]   = '0;
        bucket_q[c] = '0;
      end
      clear_columns();
      readout_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CmdReadout) emit_readout();
        else fold_row(s_axis_tdata);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[4:2] < 4) mode_q[paddr[3:2]] = pwdata[3:0];
        else bucket_q[paddr[3:2]] = pwdata;
      end
    end
  end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
  import caa_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [519:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tlast;
  logic         m_axis_tready = 1'b1;
  logic [519:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel, penable, pwrite, pready;
  logic [4:0]   paddr;
  logic [31:0]  pwdata, prdata;
  int           fail_count, pending;
  int           burst_left = 0;
  logic         hold_req = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_cnt = 0;

  column_aggregate_accumulator_unit u_top (.*);

  aggregate_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if ((($time / 800) % 3) == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: return '0;
      3: return '1;
      4: return 64'($signed($urandom_range(0, 2000)) - 1000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // setup and access cycles; the caller returns the bus to idle
  task automatic apb_write(input int idx, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx * 4); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [3:0] m0, m1, m2, m3,
                           input logic [31:0] b0, b1, b2, b3);
    apb_write(0, {$urandom} & 32'hFFFF_FFF0 | 32'(m0));
    apb_write(1, 32'(m1)); apb_write(2, 32'(m2)); apb_write(3, 32'(m3));
    apb_write(4, b0); apb_write(5, b1); apb_write(6, b2); apb_write(7, b3);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one transaction on the input stream, bursts with random gaps
  task automatic send(input logic cmd, input logic [519:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic send_row(input logic [63:0] v[4], input logic [63:0] w[4],
                          input logic [3:0] vp, input logic [3:0] wp);
    send(CmdAccum, {wp, vp, w[3], w[2], w[1], w[0], v[3], v[2], v[1], v[0]});
  endtask

  task automatic send_random_row();
    logic [63:0] v[4], w[4];
    for (int c = 0; c < 4; c++) begin
      v[c] = pick_value();
      w[c] = pick_value();
    end
    send_row(v, w, 4'($urandom), 4'($urandom));
  endtask

  task automatic readout();
    send(CmdReadout, 520'({8{$urandom}}));
  endtask

  // let results drain and any divider finish before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [3:0] pick_mode();
    return ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                       : 4'($urandom_range(0, 8));
  endfunction

  function automatic logic [31:0] pick_bucket();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return $urandom_range(2, 100);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [63:0] v[4], w[4];
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0; s_axis_tuser <= CmdAccum; s_axis_tdata <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // count, sum, avg, min over field extremes, partial presence
    configure(ModeCount, ModeSum, ModeAvg, ModeMin, 0, 0, 0, 0);
    v = '{64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, '1};
    w = '{'1, '0, '1, '0};
    send_row(v, w, 4'hF, 4'hF);
    v = '{64'd5, 64'd1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000};
    send_row(v, w, 4'hF, 4'h0);
    v = '{'0, 64'd3, 64'd7, '0};
    send_row(v, w, 4'h0, 4'hF);
    readout();
    readout();
    settle();

    // max, vwap, first/last, xbar with rounding to 7
    configure(ModeMax, ModeVwap, ModeFirstLast, ModeXbar, 0, 0, 0, 32'd7);
    v = '{64'h8000_0000_0000_0000, 64'd100, 64'd11, -64'sd20};
    w = '{'0, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0};
    send_row(v, w, 4'hF, 4'hF);
    v = '{64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd12, 64'd50};
    w = '{'0, 64'd3, '0, '0};
    send_row(v, w, 4'hF, 4'h1);
    send_row(v, w, 4'h2, 4'hF);
    v = '{64'd1, 64'd2, 64'd13, 64'd99};
    send_row(v, w, 4'hF, 4'hF);
    readout();
    settle();

    // xbar bucket extremes, unused mode codes
    configure(ModeXbar, ModeXbar, ModeXbar, 4'd15, 0, 1, 32'hFFFF_FFFF, 0);
    v = '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
          64'h8000_0000_0000_0000, 64'd4};
    send_row(v, w, 4'hF, 4'hF);
    readout();
    settle();
    configure(ModeXbar, ModeNone, ModeXbar, 4'd9, 32'hFFFF_FFFF, 0, 0, 0);
    v = '{64'h7FFF_FFFF_FFFF_FFFF, 64'd1, -64'sd5, 64'd4};
    send_row(v, w, 4'hF, 4'hF);
    v = '{64'hFFFF_FFFF, 64'd1, 64'd8, 64'd4};
    send_row(v, w, 4'hF, 4'hF);
    readout();
    settle();

    // random phases: rows then a readout, four groups per setting
    for (int ph = 0; ph < 7; ph++) begin
      configure(pick_mode(), pick_mode(), pick_mode(), pick_mode(),
                pick_bucket(), pick_bucket(), pick_bucket(), pick_bucket());
      if (ph == 3) hold_req <= 1'b1;
      for (int g = 0; g < 4; g++) begin
        repeat ($urandom_range(0, 10)) send_random_row();
        readout();
      end
      settle();
    end
    configure(ModeVwap, ModeVwap, ModeFirstLast, ModeAvg, 0, 0, 0, 0);
    repeat (20) send_random_row();
    readout();
    settle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
